FILE: hdl/rpq_pkg.sv
// Package for the refresh packet queue: request codes, packet layouts,
// controller states and the command/status structs. No dependencies.
package rpq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_PAYLOAD_BYTES_DEF = 6;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_READ   = 2'd1,
    REQ_FORGET = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [13:0] address;
    logic [7:0]  kind;
    logic        high_priority;
    logic        continuous;
    logic [6:0]  rpt_count;
    logic [2:0]  payload_size;
    logic [47:0] payload;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic        full_flag;
    logic [13:0] out_address;
    logic [7:0]  out_kind;
    logic        out_high_priority;
    logic        out_continuous;
    logic [6:0]  out_repeat_count;
    logic [2:0]  out_payload_size;
    logic [47:0] out_payload;
  } out_item_t;

  // Stored packet without payload; key is address and kind.
  typedef struct packed {
    logic [2:0]  size;
    logic [6:0]  count;
    logic        cont;
    logic        prio;
    logic [7:0]  kind;
    logic [13:0] address;
  } hdr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_REMOVE,
    ST_PLACE,
    ST_SHIFT_UP,
    ST_WRITE,
    ST_READ_FRONT,
    ST_DONE
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic latch_in;     // capture request
    logic scan_clear;   // scan index to zero
    logic scan_step;    // advance scan index, read next slot
    logic rm_begin;     // read slot idx+1 ahead of a removal sweep
    logic rm_step;      // copy slot idx+1 to idx, advance
    logic rm_done;      // count minus one
    logic up_step;      // copy slot idx-1 to idx, step down
    logic up_begin;     // index to count
    logic write_slot;   // write work packet at index, count plus one
    logic pick_front;   // index to zero (for front placement)
    logic pick_back;    // index to count
    logic take_front;   // load slot 0 as work packet, form result
    logic set_full;
    logic clr_full;
    logic set_ok;
    logic clear_all;
    logic emit;
  } dp_cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic   match;      // slot at scan index matches key
    logic   scan_end;   // scan index reached count
    logic   rm_end;     // index+1 reached count
    logic   up_end;     // index is zero
    logic   full;       // count equals depth
    logic   empty;
    logic   requeue;    // front packet goes back in
    logic   requeue_front;
    logic   work_prio;
    req_t   req;
  } dp_stat_t;

endpackage

FILE: hdl/rpq_ctrl.sv
// Controller for the refresh packet queue: sequences search, removal,
// placement and read. Depends on rpq_pkg.
module rpq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rpq_pkg::dp_stat_t stat,
  output rpq_pkg::dp_cmd_t  cmd
);

  rpq_pkg::state_t state_r, state_nxt;
  logic            read_r, read_nxt;  // placement is a read requeue

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpq_pkg::ST_IDLE;
      read_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      read_r  <= read_nxt;
    end
  end

  assign busy = (state_r != rpq_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    read_nxt  = read_r;
    cmd       = '0;
    case (state_r)
      rpq_pkg::ST_IDLE: begin
        if (start) begin
          cmd.latch_in   = 1'b1;
          cmd.scan_clear = 1'b1;
          read_nxt       = 1'b0;
          state_nxt      = rpq_pkg::ST_SEARCH;
        end
      end
      rpq_pkg::ST_SEARCH: begin
        case (stat.req)
          rpq_pkg::REQ_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_nxt     = rpq_pkg::ST_DONE;
          end
          rpq_pkg::REQ_READ: begin
            if (stat.empty) begin
              state_nxt = rpq_pkg::ST_DONE;
            end else begin
              cmd.take_front = 1'b1;
              cmd.set_ok     = 1'b1;
              state_nxt      = rpq_pkg::ST_READ_FRONT;
            end
          end
          default: begin
            if (stat.scan_end) begin
              if (stat.req == rpq_pkg::REQ_INSERT) begin
                state_nxt = rpq_pkg::ST_PLACE;
              end else begin
                state_nxt = rpq_pkg::ST_DONE;
              end
            end else if (stat.match) begin
              if (stat.req == rpq_pkg::REQ_FORGET) begin
                cmd.clr_full = 1'b1;
                cmd.set_ok   = 1'b1;
              end
              cmd.rm_begin = 1'b1;
              state_nxt    = rpq_pkg::ST_REMOVE;
            end else begin
              cmd.scan_step = 1'b1;
            end
          end
        endcase
      end
      rpq_pkg::ST_READ_FRONT: begin
        // Front slot is being removed: fetch slot 1, then shift down from index 0.
        cmd.rm_begin = 1'b1;
        read_nxt     = 1'b1;
        state_nxt    = rpq_pkg::ST_REMOVE;
      end
      rpq_pkg::ST_REMOVE: begin
        if (stat.rm_end) begin
          cmd.rm_done = 1'b1;
          if (stat.req == rpq_pkg::REQ_FORGET) begin
            state_nxt = rpq_pkg::ST_DONE;
          end else if (read_r && !stat.requeue) begin
            state_nxt = rpq_pkg::ST_DONE;
          end else begin
            state_nxt = rpq_pkg::ST_PLACE;
          end
        end else begin
          cmd.rm_step = 1'b1;
        end
      end
      rpq_pkg::ST_PLACE: begin
        if (stat.full) begin
          cmd.set_full = 1'b1;
          state_nxt    = rpq_pkg::ST_DONE;
        end else if (read_r ? stat.requeue_front : stat.work_prio) begin
          cmd.up_begin = 1'b1;
          state_nxt    = rpq_pkg::ST_SHIFT_UP;
        end else begin
          cmd.pick_back = 1'b1;
          state_nxt     = rpq_pkg::ST_WRITE;
        end
      end
      rpq_pkg::ST_SHIFT_UP: begin
        if (stat.up_end) begin
          cmd.pick_front = 1'b1;
          state_nxt      = rpq_pkg::ST_WRITE;
        end else begin
          cmd.up_step = 1'b1;
        end
      end
      rpq_pkg::ST_WRITE: begin
        cmd.write_slot = 1'b1;
        if (!read_r) cmd.set_ok = 1'b1;
        state_nxt = rpq_pkg::ST_DONE;
      end
      rpq_pkg::ST_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = rpq_pkg::ST_IDLE;
      end
      default: state_nxt = rpq_pkg::ST_IDLE;
    endcase
  end

  // A result strobe only follows a busy period.
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> busy) else $error("emit while idle");
  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted request not started");
  a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_slot |-> !stat.full) else $error("write into full queue");

endmodule

FILE: hdl/rpq_datapath.sv
// Datapath for the refresh packet queue: packet memory, count, scan index,
// work packet and result register. Depends on rpq_pkg.
module rpq_datapath #(
  parameter int QUEUE_DEPTH       = rpq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_PAYLOAD_BYTES = rpq_pkg::MAX_PAYLOAD_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rpq_pkg::in_item_t    in_item,
  input  rpq_pkg::dp_cmd_t     cmd,
  output rpq_pkg::dp_stat_t    stat,
  output logic                 out_valid,
  output rpq_pkg::out_item_t   out_item
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  // The size field cannot exceed 7, so a larger byte limit never saturates.
  localparam int SIZE_CAP = (MAX_PAYLOAD_BYTES > 7) ? 7 : MAX_PAYLOAD_BYTES;
  localparam logic [2:0] MAX_SIZE = 3'(SIZE_CAP);

  typedef struct packed {
    rpq_pkg::hdr_t hdr;
    logic [47:0]   pay;
  } pkt_t;

  pkt_t          mem [QUEUE_DEPTH];
  pkt_t          rd_r;          // registered read of slot idx
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r, idx_nxt;
  pkt_t          work_r;
  logic [21:0]   key_r;
  rpq_pkg::req_t req_r;
  logic          full_r, ok_r;
  rpq_pkg::out_item_t res_r;
  logic          valid_r;
  logic          rd_ok_r;       // rd_r holds slot idx_r
  logic          rqc_r;         // front packet had cont set or a count above zero
  logic [CW-1:0] rd_addr;
  logic [2:0]    size_sat;
  logic [47:0]   pay_mask;
  rpq_pkg::hdr_t fhdr;

  always_comb begin
    size_sat = (in_item.payload_size > MAX_SIZE) ? MAX_SIZE : in_item.payload_size;
    pay_mask = '0;
    for (int b = 0; b < 6; b++) begin
      if (3'(b) < size_sat && b < MAX_PAYLOAD_BYTES) pay_mask[b*8 +: 8] = 8'hFF;
    end
  end

  // Address of the memory read issued this cycle.
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.scan_clear) idx_nxt = '0;
    else if (cmd.scan_step || cmd.rm_step) idx_nxt = idx_r + 1'b1;
    else if (cmd.up_begin) idx_nxt = count_r;
    else if (cmd.up_step) idx_nxt = idx_r - 1'b1;
    else if (cmd.pick_front) idx_nxt = '0;
    else if (cmd.pick_back) idx_nxt = count_r;
    rd_addr = idx_nxt;
    if (cmd.rm_begin || cmd.rm_step) rd_addr = idx_nxt + 1'b1;
    if (cmd.up_begin || cmd.up_step) rd_addr = idx_nxt - 1'b1;
  end

  // Memory: one write, one registered read per cycle.
  always_ff @(posedge clk) begin
    rd_r <= mem[rd_addr[IW-1:0]];
    if (cmd.write_slot) mem[idx_r[IW-1:0]] <= work_r;
    else if (cmd.rm_step) mem[idx_r[IW-1:0]] <= rd_r;
    else if (cmd.up_step) mem[idx_r[IW-1:0]] <= rd_r;
  end

  // Status read data for the following cycle: during a removal sweep rd_r
  // holds slot idx+1; during a shift-up it holds slot idx-1.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      full_r  <= 1'b0;
      ok_r    <= 1'b0;
      valid_r <= 1'b0;
      rd_ok_r <= 1'b0;
      req_r   <= rpq_pkg::REQ_INSERT;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= cmd.emit;
      rd_ok_r <= cmd.scan_clear || cmd.scan_step;
      if (cmd.latch_in) begin
        req_r <= rpq_pkg::req_t'(in_item.req_type);
        ok_r  <= 1'b0;
      end
      if (cmd.set_ok) ok_r <= 1'b1;
      if (cmd.set_full) full_r <= 1'b1;
      if (cmd.clr_full) full_r <= 1'b0;
      if (cmd.clear_all) count_r <= '0;
      else if (cmd.rm_done) count_r <= count_r - 1'b1;
      else if (cmd.write_slot) count_r <= count_r + 1'b1;
    end
  end

  // Front packet after read: decrement a finite count.
  always_comb begin
    fhdr = rd_r.hdr;
    if (!rd_r.hdr.cont && rd_r.hdr.count != '0) fhdr.count = rd_r.hdr.count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      key_r             <= {in_item.kind, in_item.address};
      work_r.hdr.address <= in_item.address;
      work_r.hdr.kind    <= in_item.kind;
      work_r.hdr.prio    <= in_item.high_priority;
      work_r.hdr.cont    <= in_item.continuous;
      work_r.hdr.count   <= in_item.rpt_count;
      work_r.hdr.size    <= size_sat;
      work_r.pay         <= in_item.payload & pay_mask;
      res_r              <= '0;
    end else if (cmd.take_front) begin
      work_r.hdr <= fhdr;
      work_r.pay <= rd_r.pay;
      res_r.out_address       <= fhdr.address;
      res_r.out_kind          <= fhdr.kind;
      res_r.out_high_priority <= fhdr.prio;
      res_r.out_continuous    <= fhdr.cont;
      res_r.out_repeat_count  <= fhdr.count;
      res_r.out_payload_size  <= fhdr.size;
      res_r.out_payload       <= rd_r.pay;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_front) rqc_r <= rd_r.hdr.cont || (rd_r.hdr.count != '0);
  end

  assign stat.match    = rd_ok_r && (idx_r < count_r) &&
                         ({rd_r.hdr.kind, rd_r.hdr.address} == key_r);
  assign stat.scan_end = rd_ok_r && (idx_r >= count_r);
  assign stat.rm_end   = (CW'(idx_r + 1'b1) >= count_r);
  assign stat.up_end   = (idx_r == '0);
  assign stat.full     = (count_r == CW'(QUEUE_DEPTH));
  assign stat.empty    = (count_r == '0);
  assign stat.requeue  = rqc_r;
  assign stat.requeue_front = !work_r.hdr.cont && work_r.hdr.prio;
  assign stat.work_prio     = work_r.hdr.prio;
  assign stat.req           = req_r;

  assign out_valid = valid_r;
  always_comb begin
    out_item           = res_r;
    out_item.ok        = ok_r;
    out_item.full_flag = full_r;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH)) else $error("count above depth");
  a_no_wrap_remove: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rm_done |-> count_r != '0) else $error("remove from empty queue");
  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_full |=> full_r) else $error("full flag not set");

endmodule

FILE: hdl/refresh_packet_queue.sv
// Top level of the refresh packet queue: controller plus datapath.
// Search, removal and front insertion sweep the memory one slot per cycle.
// One transaction at a time; busy is high until the result strobe.
// Synchronous active-low reset empties the queue and clears the full flag.
// The result is shown for one cycle on out_valid; the receiver cannot stall.
module refresh_packet_queue #(
  parameter int QUEUE_DEPTH       = rpq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_PAYLOAD_BYTES = rpq_pkg::MAX_PAYLOAD_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rpq_pkg::in_item_t  in_item,
  output logic               out_valid,
  output rpq_pkg::out_item_t out_item
);

  rpq_pkg::dp_cmd_t  cmd;
  rpq_pkg::dp_stat_t stat;

  rpq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  rpq_datapath #(
    .QUEUE_DEPTH       (QUEUE_DEPTH),
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: verif/tb_refresh_packet_queue.sv
// Self-checking testbench for refresh_packet_queue: directed table then random requests.
// Depends on rpq_pkg and the refresh_packet_queue RTL only.
`timescale 1ns / 100ps

module tb_refresh_packet_queue;

  localparam int DEPTH     = rpq_pkg::QUEUE_DEPTH_DEF;
  localparam int MAX_BYTES = rpq_pkg::MAX_PAYLOAD_BYTES_DEF;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [2:0]  size;
    logic [6:0]  count;
    logic        cont;
    logic        prio;
    logic [7:0]  kind;
    logic [13:0] address;
    logic [47:0] payload;
  } pkt_t;

  typedef struct {
    rpq_pkg::in_item_t  req;
    bit                 has_expect;
    rpq_pkg::out_item_t expected;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  rpq_pkg::in_item_t  in_item;
  logic               out_valid;
  rpq_pkg::out_item_t out_item;

  pkt_t               queue_model[$];
  bit                 full_model;
  rpq_pkg::out_item_t pending_results[$];
  int                 failures;
  int                 idle_cycles;
  bit                 quiet_stretch;
  row_t               directed[$];

  refresh_packet_queue DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int find_key(logic [13:0] addr, logic [7:0] kind);
    for (int i = 0; i < queue_model.size(); i++) begin
      if (queue_model[i].address == addr && queue_model[i].kind == kind) return i;
    end
    return -1;
  endfunction

  // Applies one request to the queue model and returns the expected response.
  function automatic rpq_pkg::out_item_t predict_queue(rpq_pkg::in_item_t r);
    rpq_pkg::out_item_t res;
    pkt_t               p;
    int                 pos;
    logic [2:0]         sz;
    res = '0;
    case (rpq_pkg::req_t'(r.req_type))
      rpq_pkg::REQ_INSERT: begin
        sz = (r.payload_size > MAX_BYTES) ? 3'(MAX_BYTES) : r.payload_size;
        p.size = sz;
        p.count = r.rpt_count;
        p.cont = r.continuous;
        p.prio = r.high_priority;
        p.kind = r.kind;
        p.address = r.address;
        p.payload = r.payload & ((48'd1 << (sz * 8)) - 48'd1);
        pos = find_key(r.address, r.kind);
        if (pos >= 0) queue_model.delete(pos);
        if (queue_model.size() >= DEPTH) begin
          full_model = 1'b1;
        end else begin
          if (p.prio) queue_model.insert(0, p);
          else queue_model.insert(queue_model.size(), p);
          res.ok = 1'b1;
        end
      end
      rpq_pkg::REQ_READ: begin
        if (queue_model.size() > 0) begin
          p = queue_model[0];
          queue_model.delete(0);
          if (p.cont) begin
            queue_model.insert(queue_model.size(), p);
          end else if (p.count > 0) begin
            p.count = p.count - 7'd1;
            if (p.prio) queue_model.insert(0, p);
            else queue_model.insert(queue_model.size(), p);
          end
          res.ok = 1'b1;
          res.out_address = p.address;
          res.out_kind = p.kind;
          res.out_high_priority = p.prio;
          res.out_continuous = p.cont;
          res.out_repeat_count = p.count;
          res.out_payload_size = p.size;
          res.out_payload = p.payload;
        end
      end
      rpq_pkg::REQ_FORGET: begin
        pos = find_key(r.address, r.kind);
        if (pos >= 0) begin
          queue_model.delete(pos);
          full_model = 1'b0;
          res.ok = 1'b1;
        end
      end
      default: queue_model.delete();
    endcase
    res.full_flag = full_model;
    return res;
  endfunction

  function automatic rpq_pkg::in_item_t make_req(rpq_pkg::req_t op, int addr, int kind,
                                                 int hp, int cont, int cnt, int sz,
                                                 logic [47:0] pay);
    rpq_pkg::in_item_t r;
    r.req_type = op;
    r.address = 14'(addr);
    r.kind = 8'(kind);
    r.high_priority = 1'(hp);
    r.continuous = 1'(cont);
    r.rpt_count = 7'(cnt);
    r.payload_size = 3'(sz);
    r.payload = pay;
    return r;
  endfunction

  // Random request; addresses mostly from a small pool so matches happen often.
  function automatic rpq_pkg::in_item_t random_req();
    rpq_pkg::in_item_t r;
    int                pick;
    r.address = 14'($urandom);
    r.kind = 8'($urandom);
    r.high_priority = 1'($urandom);
    r.continuous = 1'($urandom);
    r.rpt_count = 7'($urandom);
    r.payload_size = 3'($urandom);
    r.payload = {16'($urandom), $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 45) r.req_type = rpq_pkg::REQ_INSERT;
    else if (pick < 85) r.req_type = rpq_pkg::REQ_READ;
    else if (pick < 97) r.req_type = rpq_pkg::REQ_FORGET;
    else r.req_type = rpq_pkg::REQ_CLEAR;
    if ($urandom_range(0, 3) != 0) begin
      r.address = 14'($urandom_range(0, 11));
      r.kind = 8'($urandom_range(0, 1));
    end
    if ($urandom_range(0, 2) != 0) r.rpt_count = 7'($urandom_range(0, 3));
    return r;
  endfunction

  function automatic rpq_pkg::out_item_t fixed_result(int ok, int full);
    rpq_pkg::out_item_t o;
    o = '0;
    o.ok = 1'(ok);
    o.full_flag = 1'(full);
    return o;
  endfunction

  // Holds start until the transaction is accepted; returns at the accepting edge.
  task automatic send_request(rpq_pkg::in_item_t r, bit has_expect,
                              rpq_pkg::out_item_t typed);
    rpq_pkg::out_item_t predicted;
    while (!quiet_stretch && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      @(posedge clk);
    end
    predicted = predict_queue(r);
    pending_results.insert(pending_results.size(), has_expect ? typed : predicted);
    start   <= 1'b1;
    in_item <= r;
    // busy only changes at rising edges, so its falling-edge value holds at the next one.
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // Checks every result strobe against the oldest expectation.
  always @(posedge clk) begin
    rpq_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result %h", out_item);
        failures++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_item.ok !== want.ok) begin
          $error("ok: expected %0d actual %0d", want.ok, out_item.ok); failures++;
        end
        if (out_item.full_flag !== want.full_flag) begin
          $error("full_flag: expected %0d actual %0d", want.full_flag, out_item.full_flag);
          failures++;
        end
        if (out_item.out_address !== want.out_address) begin
          $error("out_address: expected %0h actual %0h", want.out_address,
                 out_item.out_address); failures++;
        end
        if (out_item.out_kind !== want.out_kind) begin
          $error("out_kind: expected %0h actual %0h", want.out_kind, out_item.out_kind);
          failures++;
        end
        if (out_item.out_high_priority !== want.out_high_priority) begin
          $error("out_high_priority: expected %0d actual %0d", want.out_high_priority,
                 out_item.out_high_priority); failures++;
        end
        if (out_item.out_continuous !== want.out_continuous) begin
          $error("out_continuous: expected %0d actual %0d", want.out_continuous,
                 out_item.out_continuous); failures++;
        end
        if (out_item.out_repeat_count !== want.out_repeat_count) begin
          $error("out_repeat_count: expected %0d actual %0d", want.out_repeat_count,
                 out_item.out_repeat_count); failures++;
        end
        if (out_item.out_payload_size !== want.out_payload_size) begin
          $error("out_payload_size: expected %0d actual %0d", want.out_payload_size,
                 out_item.out_payload_size); failures++;
        end
        if (out_item.out_payload !== want.out_payload) begin
          $error("out_payload: expected %0h actual %0h", want.out_payload,
                 out_item.out_payload); failures++;
        end
      end
    end
  end

  // Watchdog: counts cycles without an accepted request or result.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    row_t row;
    full_model = 1'b0;
    quiet_stretch = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; rows with a typed result are obvious from the spec.
    directed.push_back('{make_req(rpq_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, '0), 1'b1,
                         fixed_result(0, 0)});
    directed.push_back('{make_req(rpq_pkg::REQ_FORGET, 5, 1, 0, 0, 0, 0, '0), 1'b1,
                         fixed_result(0, 0)});
    directed.push_back('{make_req(rpq_pkg::REQ_INSERT, 16383, 255, 1, 0, 127, 7,
                                  48'hFFFF_FFFF_FFFF), 1'b1, fixed_result(1, 0)});
    directed.push_back('{make_req(rpq_pkg::REQ_INSERT, 0, 0, 0, 1, 9, 0, 48'h1234), 1'b1,
                         fixed_result(1, 0)});
    directed.push_back('{make_req(rpq_pkg::REQ_INSERT, 7, 3, 0, 0, 1, 3, 48'hAABBCCDD),
                         1'b0, '0});
    directed.push_back('{make_req(rpq_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, '0), 1'b0, '0});
    directed.push_back('{make_req(rpq_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, '0), 1'b0, '0});
    directed.push_back('{make_req(rpq_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, '0), 1'b0, '0});
    directed.push_back('{make_req(rpq_pkg::REQ_INSERT, 7, 3, 1, 0, 2, 6, 48'h0102_0304_0506),
                         1'b0, '0});
    directed.push_back('{make_req(rpq_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, '0), 1'b1,
                         fixed_result(0, 0)});
    directed.push_back('{make_req(rpq_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, '0), 1'b1,
                         fixed_result(0, 0)});
    for (int i = 0; i < DEPTH; i++)
      directed.push_back('{make_req(rpq_pkg::REQ_INSERT, 100 + i, 2, 0, 0, 0, 1, 48'hFF),
                           1'b1, fixed_result(1, 0)});
    // Full queue: a new key fails and sets the flag; a matching key still fits.
    directed.push_back('{make_req(rpq_pkg::REQ_INSERT, 999, 2, 1, 0, 0, 0, '0), 1'b1,
                         fixed_result(0, 1)});
    directed.push_back('{make_req(rpq_pkg::REQ_INSERT, 103, 2, 1, 0, 0, 0, '0), 1'b1,
                         fixed_result(1, 1)});
    directed.push_back('{make_req(rpq_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, '0), 1'b1,
                         fixed_result(0, 1)});
    directed.push_back('{make_req(rpq_pkg::REQ_FORGET, 103, 2, 0, 0, 0, 0, '0), 1'b1,
                         fixed_result(0, 1)});
    directed.push_back('{make_req(rpq_pkg::REQ_INSERT, 103, 2, 0, 0, 0, 0, '0), 1'b1,
                         fixed_result(1, 1)});
    directed.push_back('{make_req(rpq_pkg::REQ_FORGET, 103, 2, 0, 0, 0, 0, '0), 1'b1,
                         fixed_result(1, 0)});

    foreach (directed[i]) begin
      row = directed[i];
      send_request(row.req, row.has_expect, row.expected);
    end

    for (int n = 0; n < 1700; n++) begin
      quiet_stretch = (n >= 600 && n < 900);
      send_request(random_req(), 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 10) @(posedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/rpq_pkg.sv
hdl/rpq_ctrl.sv
hdl/rpq_datapath.sv
hdl/refresh_packet_queue.sv
verif/tb_refresh_packet_queue.sv
